[src/cmap_pkg.sv]
// Shared types and constants for the character-map subtable partitioner.
// Holds the channel word structs, the table format codes and the control state type.
// No dependencies.
package cmap_pkg;

  localparam int DEFAULT_MAX_POINTS = 64;
  localparam int CP_W = 21;
  localparam int GLYPH_W = 7;

  // Cost terms of one subtable.
  localparam int COST_HDR = 16;
  localparam int SPAN_DENSE = 256;
  localparam int SPAN_SPARSE = 65536;

  typedef enum logic [1:0] {
    FMT_HEADER = 2'd0,
    FMT_DENSE  = 2'd1,
    FMT_SPARSE = 2'd2
  } fmt_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last_point;
  } point_word_t;

  typedef struct packed {
    fmt_t               table_format;
    logic [CP_W-1:0]    range_first;
    logic [CP_W-1:0]    range_last;
    logic [GLYPH_W-1:0] first_glyph;
    logic [GLYPH_W-1:0] point_count;
    logic               final_table;
  } subtable_word_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_SO_RD_I,
    S_SO_GET,
    S_SO_RD_K,
    S_SO_CMP,
    S_SO_PUT,
    S_D_RD_I,
    S_D_GET,
    S_D_RD_J,
    S_D_EVAL,
    S_D_WR,
    S_B_RD,
    S_B_GET,
    S_E_RD_RUN,
    S_E_RD_S,
    S_E_RD_E,
    S_E_CAP,
    S_E_WAIT
  } state_t;

endpackage

[src/cmap_subtable_partition_dp.sv]
// Takes one loaded word per cycle while in the load state; after the last word it runs an insertion sort,
// a split search (one start/end pair at a time through the point and split memories), a backtrack
// over the split table and then emits one subtable per run.
// Works on one set at a time: no new point is taken until the final subtable has been accepted.
// Reset: rst clears the controller and the loaded count; memory contents are not cleared.
module cmap_subtable_partition_dp #(
  parameter int MAX_POINTS = cmap_pkg::DEFAULT_MAX_POINTS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     point_valid,
  output logic                     point_stall,
  input  cmap_pkg::point_word_t    point,
  output logic                     subtable_valid,
  input  logic                     subtable_stall,
  output cmap_pkg::subtable_word_t subtable
);
  import cmap_pkg::*;

  // Index width addresses the stores; count width can also hold MAX_POINTS itself.
  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  // Every candidate cost stays below this bound, so compares never wrap.
  localparam int COST_W = $clog2(MAX_POINTS * 20 + 300);
  localparam int DP_W = COST_W + IW + 2;
  localparam int RUN_W = 2 + 2 * IW;

  state_t state, state_next;

  logic [CW-1:0] cnt;        // loaded points, and the set size while working
  logic [CW-1:0] i;          // outer index of sort and split search
  logic [IW-1:0] k;          // insertion position of the sort
  logic [IW-1:0] j;          // candidate start of the split search
  logic [IW-1:0] e;          // end of the run being traced back
  logic [CW-1:0] runs;       // number of runs found by the trace
  logic [IW-1:0] t;          // run being emitted, last stored first
  logic [CP_W-1:0] v;        // word being inserted by the sort
  logic [CP_W-1:0] pi;       // point at the end of the current prefix
  logic [CP_W-1:0] pnext;    // point just above j, for the gap test
  logic            gf;       // run j+1..i has no gaps
  logic            bvalid;
  logic [COST_W-1:0] best;
  logic [IW-1:0]     bstart;
  fmt_t              bfmt;
  logic [GLYPH_W-1:0] glyph;
  logic [RUN_W-1:0]   rec;
  logic [CP_W-1:0]    first_cp;

  // Memory ports.
  logic            p_we, p_re;
  logic [IW-1:0]   p_waddr, p_raddr;
  logic [CP_W-1:0] p_wdata, p_rdata;
  logic            d_we, d_re;
  logic [IW-1:0]   d_waddr, d_raddr;
  logic [DP_W-1:0] d_wdata, d_rdata;
  logic             r_we, r_re;
  logic [IW-1:0]    r_waddr, r_raddr;
  logic [RUN_W-1:0] r_wdata, r_rdata;

  // Split table entry fields as read back.
  logic [COST_W-1:0] d_cost;
  logic [IW-1:0]     d_start;
  fmt_t              d_fmt;
  assign d_cost  = d_rdata[DP_W-1 -: COST_W];
  assign d_start = d_rdata[IW+1:2];
  assign d_fmt   = fmt_t'(d_rdata[1:0]);

  // Run list entry fields: format, start index, end index.
  logic [IW-1:0] r_s, rec_s, rec_e;
  assign r_s   = r_rdata[2*IW-1:IW];
  assign rec_s = rec[2*IW-1:IW];
  assign rec_e = rec[IW-1:0];

  logic accept_in;
  logic full;
  logic [CW-1:0] cnt_after;
  assign accept_in = point_valid && !point_stall;
  assign full      = cnt >= CW'(MAX_POINTS);
  assign cnt_after = full ? cnt : cnt + CW'(1);

  // Cost evaluation for start j of the current prefix.
  logic              gf_j;
  logic [COST_W-1:0] prev_cost;
  logic [CW-1:0]     run_len;
  logic              cand_valid;
  logic [COST_W-1:0] cand_cost;
  fmt_t              cand_fmt;
  logic              take;

  assign gf_j      = (CW'(j) == i) ? 1'b1
                   : gf && ({1'b0, pnext} == {1'b0, p_rdata} + (CP_W + 1)'(1));
  assign prev_cost = (j == '0) ? '0 : d_cost;
  assign run_len   = i - CW'(j) + CW'(1);
  // Walking j downward, a tie goes to the smaller start.
  assign take      = cand_valid && (!bvalid || cand_cost <= best);

  cmap_cost #(.COST_W(COST_W), .CW(CW)) u_cost (
    .p_end     (pi),
    .p_start   (p_rdata),
    .prev      (prev_cost),
    .run_len   (run_len),
    .gap_free  (gf_j),
    .cand_valid(cand_valid),
    .cand_cost (cand_cost),
    .cand_fmt  (cand_fmt)
  );

  cmap_ram #(.WIDTH(CP_W), .DEPTH(MAX_POINTS), .AW(IW)) u_points (
    .clk(clk), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
    .rd_en(p_re), .rd_addr(p_raddr), .rd_data(p_rdata)
  );

  cmap_ram #(.WIDTH(DP_W), .DEPTH(MAX_POINTS), .AW(IW)) u_splits (
    .clk(clk), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
    .rd_en(d_re), .rd_addr(d_raddr), .rd_data(d_rdata)
  );

  cmap_ram #(.WIDTH(RUN_W), .DEPTH(MAX_POINTS), .AW(IW)) u_runs (
    .clk(clk), .wr_en(r_we), .wr_addr(r_waddr), .wr_data(r_wdata),
    .rd_en(r_re), .rd_addr(r_raddr), .rd_data(r_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:     if (accept_in && point.last_point) state_next = S_SO_RD_I;
      S_SO_RD_I:  state_next = (i < cnt) ? S_SO_GET : S_D_RD_I;
      S_SO_GET:   state_next = S_SO_RD_K;
      S_SO_RD_K:  state_next = S_SO_CMP;
      S_SO_CMP: begin
        if (p_rdata > v) begin
          state_next = (k == IW'(1)) ? S_SO_PUT : S_SO_RD_K;
        end else begin
          state_next = S_SO_RD_I;
        end
      end
      S_SO_PUT:   state_next = S_SO_RD_I;
      S_D_RD_I:   state_next = (i < cnt) ? S_D_GET : S_B_RD;
      S_D_GET:    state_next = S_D_RD_J;
      S_D_RD_J:   state_next = S_D_EVAL;
      S_D_EVAL:   state_next = (j == '0) ? S_D_WR : S_D_RD_J;
      S_D_WR:     state_next = S_D_RD_I;
      S_B_RD:     state_next = S_B_GET;
      S_B_GET:    state_next = (d_start == '0) ? S_E_RD_RUN : S_B_RD;
      S_E_RD_RUN: state_next = S_E_RD_S;
      S_E_RD_S:   state_next = S_E_RD_E;
      S_E_RD_E:   state_next = S_E_CAP;
      S_E_CAP:    state_next = S_E_WAIT;
      S_E_WAIT: begin
        if (!subtable_stall) begin
          state_next = (t == '0) ? S_LOAD : S_E_RD_RUN;
        end
      end
      default:    state_next = S_LOAD;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    point_stall = (state != S_LOAD);
    p_we = 1'b0; p_waddr = cnt[IW-1:0]; p_wdata = point.code_point;
    p_re = 1'b0; p_raddr = i[IW-1:0];
    d_we = 1'b0; d_waddr = i[IW-1:0]; d_wdata = {best, bstart, bfmt};
    d_re = 1'b0; d_raddr = j - IW'(1);
    r_we = 1'b0; r_waddr = runs[IW-1:0]; r_wdata = {d_fmt, d_start, e};
    r_re = 1'b0; r_raddr = t;
    unique case (state)
      S_LOAD:     p_we = accept_in && !full;
      S_SO_RD_I:  p_re = 1'b1;
      S_SO_RD_K: begin
        p_re    = 1'b1;
        p_raddr = k - IW'(1);
      end
      S_SO_CMP: begin
        p_we    = 1'b1;
        p_waddr = k;
        p_wdata = (p_rdata > v) ? p_rdata : v;
      end
      S_SO_PUT: begin
        p_we    = 1'b1;
        p_waddr = k;
        p_wdata = v;
      end
      S_D_RD_I:   p_re = 1'b1;
      S_D_RD_J: begin
        p_re    = 1'b1;
        p_raddr = j;
        d_re    = 1'b1;
      end
      S_D_WR:     d_we = 1'b1;
      S_B_RD: begin
        d_re    = 1'b1;
        d_raddr = e;
      end
      S_B_GET:    r_we = 1'b1;
      S_E_RD_RUN: r_re = 1'b1;
      S_E_RD_S: begin
        p_re    = 1'b1;
        p_raddr = r_s;
      end
      S_E_RD_E: begin
        p_re    = 1'b1;
        p_raddr = rec_e;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Counters, which are control state, clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt            <= '0;
      subtable_valid <= 1'b0;
    end else begin
      if (state == S_LOAD && accept_in) begin
        cnt <= cnt_after;
      end
      if (state == S_E_CAP) begin
        subtable_valid <= 1'b1;
      end
      if (state == S_E_WAIT && !subtable_stall) begin
        subtable_valid <= 1'b0;
        if (t == '0) begin
          cnt <= '0;
        end
      end
    end
  end

  // Datapath registers for sort, split search, trace and emit.
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: i <= CW'(1);
      S_SO_RD_I: begin
        if (i >= cnt) begin
          i <= '0;
        end
      end
      S_SO_GET: begin
        v <= p_rdata;
        k <= i[IW-1:0];
      end
      S_SO_CMP: begin
        if (p_rdata > v) begin
          k <= k - IW'(1);
        end else begin
          i <= i + CW'(1);
        end
      end
      S_SO_PUT: i <= i + CW'(1);
      S_D_RD_I: begin
        e    <= IW'(cnt - CW'(1));
        runs <= '0;
      end
      S_D_GET: begin
        pi     <= p_rdata;
        j      <= i[IW-1:0];
        gf     <= 1'b1;
        bvalid <= 1'b0;
      end
      S_D_EVAL: begin
        gf    <= gf_j;
        pnext <= p_rdata;
        if (take) begin
          bvalid <= 1'b1;
          best   <= cand_cost;
          bstart <= j;
          bfmt   <= cand_fmt;
        end
        if (j != '0) begin
          j <= j - IW'(1);
        end
      end
      S_D_WR: i <= i + CW'(1);
      S_B_GET: begin
        runs <= runs + CW'(1);
        e    <= d_start - IW'(1);
        t     <= runs[IW-1:0];
        glyph <= GLYPH_W'(1);
      end
      S_E_RD_S: rec <= r_rdata;
      S_E_RD_E: first_cp <= p_rdata;
      S_E_CAP: begin
        subtable.table_format <= fmt_t'(rec[RUN_W-1 -: 2]);
        subtable.range_first  <= first_cp;
        subtable.range_last   <= p_rdata;
        subtable.first_glyph  <= glyph;
        subtable.point_count  <= GLYPH_W'(CW'(rec_e) - CW'(rec_s) + CW'(1));
        subtable.final_table  <= (t == '0);
      end
      S_E_WAIT: begin
        if (!subtable_stall) begin
          glyph <= glyph + subtable.point_count;
          if (t != '0) begin
            t <= t - IW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // A candidate start never lies beyond the end of its prefix.
  a_start_in_prefix: assert property (@(posedge clk) disable iff (rst)
    (state == S_D_EVAL) |-> (CW'(j) <= i))
    else $error("split search start beyond prefix end");

  // Points are sorted, so every subtable covers an ascending range.
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    subtable_valid |-> (subtable.range_first <= subtable.range_last))
    else $error("subtable range out of order");

  // Once the final subtable is taken the block returns to loading.
  a_final_returns: assert property (@(posedge clk) disable iff (rst)
    (subtable_valid && !subtable_stall && subtable.final_table)
      |=> (!subtable_valid && !point_stall))
    else $error("block did not return to loading after final subtable");

  // No word is taken while a subtable is pending.
  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    subtable_valid |-> point_stall)
    else $error("input taken while a subtable is pending");

endmodule

[src/cmap_ram.sv]
// Simple dual-port synchronous RAM with one write and one registered read port.
// Used for the point store, the split table and the run list; does not depend on cmap_pkg.
module cmap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/cmap_cost.sv]
// Cost evaluator for one candidate subtable that spans points j through i.
// Picks the cheapest format allowed for that run, first tried winning ties; depends on cmap_pkg.
module cmap_cost #(
  parameter int COST_W = 11,
  parameter int CW = 7
) (
  input  logic [cmap_pkg::CP_W-1:0] p_end,
  input  logic [cmap_pkg::CP_W-1:0] p_start,
  input  logic [COST_W-1:0]         prev,
  input  logic [CW-1:0]             run_len,
  input  logic                      gap_free,
  output logic                      cand_valid,
  output logic [COST_W-1:0]         cand_cost,
  output cmap_pkg::fmt_t            cand_fmt
);
  import cmap_pkg::*;

  logic [CP_W-1:0]   span;
  logic              near;
  logic              mid;
  logic [COST_W-1:0] dense_c;
  logic [COST_W-1:0] hdr_c;
  logic [COST_W-1:0] sparse_c;

  assign span = p_end - p_start;
  assign near = span < CP_W'(SPAN_DENSE);
  assign mid  = span < CP_W'(SPAN_SPARSE);

  assign dense_c  = prev + COST_W'(COST_HDR + 1) + COST_W'(span[7:0]);
  assign hdr_c    = prev + COST_W'(COST_HDR);
  assign sparse_c = prev + COST_W'(COST_HDR) + (COST_W'(run_len) << 1);

  always_comb begin
    cand_valid = mid;
    cand_cost  = sparse_c;
    cand_fmt   = FMT_SPARSE;
    if (near) begin
      cand_cost = dense_c;
      cand_fmt  = FMT_DENSE;
      if (gap_free && hdr_c < cand_cost) begin
        cand_cost = hdr_c;
        cand_fmt  = FMT_HEADER;
      end
      if (sparse_c < cand_cost) begin
        cand_cost = sparse_c;
        cand_fmt  = FMT_SPARSE;
      end
    end
  end

endmodule
